FILE: rtl/core/esm_pkg.sv
`timescale 1ns / 1ps
package esm_pkg;

  localparam int unsigned TurnsW   = 10;
  localparam int unsigned ButtonW  = 2;
  localparam int unsigned StateW   = 3;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned IdleW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW    = TurnsW + ValueW;

  typedef enum logic [StateW-1:0] {
    ST_INIT     = 3'd0,
    ST_SHOW     = 3'd1,
    ST_SEL_VOLT = 3'd2,
    ST_CHG_VOLT = 3'd3,
    ST_SEL_AMP  = 3'd4,
    ST_CHG_AMP  = 3'd5
  } menu_state_e;

  typedef enum logic [ButtonW-1:0] {
    BTN_OPEN    = 2'd0,
    BTN_CLICK   = 2'd1,
    BTN_OTHER   = 2'd2,
    BTN_UNUSED  = 2'd3
  } btn_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOLT_STEP  = 3'd0,
    CFG_VOLT_MAX   = 3'd1,
    CFG_VOLT_MIN   = 3'd2,
    CFG_AMP_STEP   = 3'd3,
    CFG_AMP_MAX    = 3'd4,
    CFG_AMP_MIN    = 3'd5,
    CFG_IDLE_LIMIT = 3'd6
  } cfg_idx_e;

  localparam logic [ValueW-1:0] VoltStepRst  = 16'd100;
  localparam logic [ValueW-1:0] VoltMaxRst   = 16'd10000;
  localparam logic [ValueW-1:0] VoltMinRst   = 16'd100;
  localparam logic [ValueW-1:0] AmpStepRst   = 16'd100;
  localparam logic [ValueW-1:0] AmpMaxRst    = 16'd2000;
  localparam logic [ValueW-1:0] AmpMinRst    = 16'd100;
  localparam logic [IdleW-1:0]  IdleLimitRst = 8'd25;
  localparam logic [ValueW-1:0] SetpointRst  = 16'd1000;

  typedef struct packed {
    logic [StateW-1:0] menu_state;
    logic [ValueW-1:0] volt_setpoint;
    logic [ValueW-1:0] amp_setpoint;
    logic              volt_apply;
    logic              amp_apply;
  } result_t;

endpackage

FILE: rtl/core/esm_in_if.sv
`timescale 1ns / 1ps
interface esm_in_if import esm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [TurnsW-1:0]  turns;
  logic        [ButtonW-1:0] button;

  modport source (output valid, output turns, output button, input ready);
  modport sink   (input valid, input turns, input button, output ready);
endinterface

FILE: rtl/core/esm_out_if.sv
`timescale 1ns / 1ps
interface esm_out_if import esm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [StateW-1:0] menu_state;
  logic [ValueW-1:0] volt_setpoint;
  logic [ValueW-1:0] amp_setpoint;
  logic              volt_apply;
  logic              amp_apply;

  modport source (output valid, output menu_state, output volt_setpoint,
                  output amp_setpoint, output volt_apply, output amp_apply,
                  input ready);
  modport sink   (input valid, input menu_state, input volt_setpoint,
                  input amp_setpoint, input volt_apply, input amp_apply,
                  output ready);
endinterface

FILE: rtl/core/encoder_setpoint_menu_core.sv
`timescale 1ns / 1ps
// Setpoint menu of a bench supply, one menu tick per item.
// in_i  : valid/ready channel with turns (signed net detents) and button.
// out_o : valid/ready channel with the menu state after the tick, both
//         setpoints and the one-tick apply flags.
// cfg   : cfg_we_i/cfg_idx_i/cfg_data_i write the step, clamp and idle-limit
//         registers; write only while no item is in flight.
// An accepted item is held in the input register; the menu logic and the
// clamped step (one 10x16 multiply, an add and a compare) settle in front of
// the result register. One item per cycle is sustained while out_o is taken;
// the input register frees up in the same cycle the result
// register is loaded.
// A stalled receiver holds the result register; the input register fills
// and then in_i.ready drops until out_o is taken.
// Reset puts the menu in init, both setpoints at 1000, both apply flags
// pending, the registers at their defaults, and empties both stages.
module encoder_setpoint_menu_core import esm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  esm_in_if.sink              in_i,
  esm_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration
  logic [ValueW-1:0] volt_step_q, volt_max_q, volt_min_q;
  logic [ValueW-1:0] amp_step_q, amp_max_q, amp_min_q;
  logic [IdleW-1:0]  idle_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_step_q  <= VoltStepRst;
      volt_max_q   <= VoltMaxRst;
      volt_min_q   <= VoltMinRst;
      amp_step_q   <= AmpStepRst;
      amp_max_q    <= AmpMaxRst;
      amp_min_q    <= AmpMinRst;
      idle_limit_q <= IdleLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOLT_STEP:  volt_step_q  <= cfg_data_i;
        CFG_VOLT_MAX:   volt_max_q   <= cfg_data_i;
        CFG_VOLT_MIN:   volt_min_q   <= cfg_data_i;
        CFG_AMP_STEP:   amp_step_q   <= cfg_data_i;
        CFG_AMP_MAX:    amp_max_q    <= cfg_data_i;
        CFG_AMP_MIN:    amp_min_q    <= cfg_data_i;
        CFG_IDLE_LIMIT: idle_limit_q <= cfg_data_i[IdleW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_fire, s1_fire;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;
  assign s1_fire  = s1_valid_q && s1_adv;

  logic [TurnsW-1:0]  turns_q;
  logic [ButtonW-1:0] button_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      turns_q  <= in_i.turns;
      button_q <= in_i.button;
    end
  end

  // menu state
  menu_state_e       state_q, state_d;
  logic [IdleW-1:0]  idle_q, idle_d, idle_inc;
  logic [ValueW-1:0] volt_q, volt_d, amp_q, amp_d;
  logic              volt_pend_q, volt_pend_d, amp_pend_q, amp_pend_d;
  logic              volt_apply, amp_apply;
  logic              turn_nz, turn_neg, click;

  assign turn_nz  = |turns_q;
  assign turn_neg = turns_q[TurnsW-1];
  assign click    = (button_q == BTN_CLICK);
  assign idle_inc = idle_q + IdleW'(1);

  always_comb begin
    state_d = state_q;
    idle_d  = idle_q;
    case (state_q)
      ST_INIT: state_d = ST_SHOW;
      ST_SHOW: begin
        if (turn_nz || button_q != BTN_OPEN) state_d = ST_SEL_VOLT;
      end
      ST_SEL_VOLT, ST_SEL_AMP: begin
        if (turn_nz) begin
          idle_d  = '0;
          state_d = (state_q == ST_SEL_VOLT) ? ST_SEL_AMP : ST_SEL_VOLT;
        end else if (click) begin
          idle_d  = '0;
          state_d = (state_q == ST_SEL_VOLT) ? ST_CHG_VOLT : ST_CHG_AMP;
        end else if (idle_inc >= idle_limit_q) begin
          idle_d  = '0;
          state_d = ST_SHOW;
        end else begin
          idle_d  = idle_inc;
        end
      end
      ST_CHG_VOLT, ST_CHG_AMP: begin
        if (click) state_d = ST_SEL_VOLT;
      end
      default: ;
    endcase
  end

  // clamped step: n detents of size s collapse to one multiply-add
  logic              chg_volt, chg_amp;
  logic [TurnsW-1:0] mag;
  logic [ValueW-1:0] cur_val, cur_step, cur_hi, cur_lo;
  logic [ProdW-1:0]  prod;
  logic [ProdW:0]    up_sum;
  logic [ValueW-1:0] dn_diff, up_res, dn_res, new_val;

  assign chg_volt = (state_d == ST_CHG_VOLT);
  assign chg_amp  = (state_d == ST_CHG_AMP);
  assign mag      = turn_neg ? (~turns_q + TurnsW'(1)) : turns_q;
  assign cur_val  = chg_amp ? amp_q      : volt_q;
  assign cur_step = chg_amp ? amp_step_q : volt_step_q;
  assign cur_hi   = chg_amp ? amp_max_q  : volt_max_q;
  assign cur_lo   = chg_amp ? amp_min_q  : volt_min_q;
  assign prod     = ProdW'(mag) * ProdW'(cur_step);
  assign up_sum   = (ProdW+1)'(cur_val) + (ProdW+1)'(prod);
  assign up_res   = (up_sum < (ProdW+1)'(cur_hi)) ? up_sum[ValueW-1:0] : cur_hi;
  assign dn_diff  = cur_val - prod[ValueW-1:0];
  // once the product reaches the value the difference is <= 0 <= min
  assign dn_res   = (prod < ProdW'(cur_val) && dn_diff > cur_lo) ? dn_diff : cur_lo;
  assign new_val  = turn_neg ? dn_res : up_res;

  always_comb begin
    volt_d      = volt_q;
    amp_d       = amp_q;
    volt_pend_d = volt_pend_q;
    amp_pend_d  = amp_pend_q;
    volt_apply  = 1'b0;
    amp_apply   = 1'b0;
    if (chg_volt) begin
      if (turn_nz) volt_d = new_val;
      volt_apply  = turn_nz || volt_pend_q;
      volt_pend_d = 1'b0;
    end else if (chg_amp) begin
      if (turn_nz) amp_d = new_val;
      amp_apply   = turn_nz || amp_pend_q;
      amp_pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      idle_q      <= '0;
      volt_q      <= SetpointRst;
      amp_q       <= SetpointRst;
      volt_pend_q <= 1'b1;
      amp_pend_q  <= 1'b1;
    end else if (s1_fire) begin
      state_q     <= state_d;
      idle_q      <= idle_d;
      volt_q      <= volt_d;
      amp_q       <= amp_d;
      volt_pend_q <= volt_pend_d;
      amp_pend_q  <= amp_pend_d;
    end
  end

  // result register
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q.menu_state    <= state_d;
      res_q.volt_setpoint <= volt_d;
      res_q.amp_setpoint  <= amp_d;
      res_q.volt_apply    <= volt_apply;
      res_q.amp_apply     <= amp_apply;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.menu_state    = res_q.menu_state;
  assign out_o.volt_setpoint = res_q.volt_setpoint;
  assign out_o.amp_setpoint  = res_q.amp_setpoint;
  assign out_o.volt_apply    = res_q.volt_apply;
  assign out_o.amp_apply     = res_q.amp_apply;

endmodule

FILE: rtl/core/esm_checker.sv
`timescale 1ns / 1ps
module esm_checker import esm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [StateW-1:0] menu_state,
  input logic [ValueW-1:0] volt_setpoint,
  input logic [ValueW-1:0] amp_setpoint,
  input logic              volt_apply,
  input logic              amp_apply
);

  // a voltage apply only comes out of the voltage change state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && volt_apply |-> menu_state == ST_CHG_VOLT)
    else $error("volt_apply outside voltage change state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && amp_apply |-> menu_state == ST_CHG_AMP)
    else $error("amp_apply outside current change state");

  // a fresh result needs an item accepted before it, passed on through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(menu_state)
      && $stable(volt_setpoint) && $stable(amp_setpoint)
      && $stable(volt_apply) && $stable(amp_apply))
    else $error("stalled result changed");

endmodule

bind encoder_setpoint_menu_core esm_checker u_esm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .menu_state    (out_o.menu_state),
  .volt_setpoint (out_o.volt_setpoint),
  .amp_setpoint  (out_o.amp_setpoint),
  .volt_apply    (out_o.volt_apply),
  .amp_apply     (out_o.amp_apply)
);
